### rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// shared types and codes for the trajectory point search block
// ----------------------------------------------------------------------------
package tps_pkg;

   localparam int unsigned FIELD_BITS   = 24;
   localparam int unsigned TABLE_POINTS = 1024;
   localparam int unsigned INDEX_BITS   = 10;
   localparam int unsigned SQD_BITS     = 50;
   localparam int unsigned ROOT_BITS    = 25;

   typedef enum logic [2:0] {
      ACT_CLEAR   = 3'd0,
      ACT_APPEND  = 3'd1,
      ACT_NEAREST = 3'd2,
      ACT_LB_STA  = 3'd3,
      ACT_LB_TIME = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_NONE    = 2'd0,
      OP_NEAREST = 2'd1,
      OP_LB_STA  = 2'd2,
      OP_LB_TIME = 2'd3
   } op_type;

   typedef struct packed {
      logic [2:0]                   action;
      logic signed [FIELD_BITS-1:0] coord_x;
      logic signed [FIELD_BITS-1:0] coord_y;
      logic [FIELD_BITS-1:0]        point_station;
      logic [FIELD_BITS-1:0]        point_time;
      logic [FIELD_BITS-1:0]        search_key;
   } req_type;

   typedef struct packed {
      logic [INDEX_BITS-1:0] found_index;
      logic [SQD_BITS-1:0]   squared_distance;
      logic [ROOT_BITS-1:0]  root_distance;
      logic [1:0]            status;
   } rsp_type;

   typedef struct packed {
      op_type                       op;
      logic [1:0]                   status;
      logic signed [FIELD_BITS-1:0] qx;
      logic signed [FIELD_BITS-1:0] qy;
      logic [FIELD_BITS-1:0]        key;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_SCAN,
      BK_DRAIN,
      BK_ROOT,
      BK_DONE
   } back_state_type;

endpackage

### rtl/tps_front.sv
// ----------------------------------------------------------------------------
// tps_front
// takes requests, keeps the point count, writes appends, classifies queries
// ----------------------------------------------------------------------------
module tps_front #(
   parameter int unsigned MAX_POINTS = 1024,
   parameter int unsigned CNT_BITS   = 11,
   parameter int unsigned ADDR_BITS  = 10,
   parameter int unsigned VALUE_BITS = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tps_pkg::req_type       req_data,
   input  logic                   back_busy,
   output logic                   cmd_valid,
   input  logic                   cmd_ready,
   output tps_pkg::cmd_type       cmd_data,
   output logic [CNT_BITS-1:0]    count,
   output logic                   wr_en,
   output logic [ADDR_BITS-1:0]   wr_addr,
   output logic [4*VALUE_BITS-1:0] wr_data
);
   import tps_pkg::*;

   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                accept, full, hold;

   // table changes wait until no queued or running query can see them
   assign hold      = back_busy && (req_data.action inside {ACT_CLEAR, ACT_APPEND});
   assign req_ready = cmd_ready && !hold;
   assign accept    = req_valid && req_ready;
   assign full      = (count_ff >= CNT_BITS'(MAX_POINTS));
   assign count     = count_ff;
   assign cmd_valid = req_valid && !hold;

   always_comb begin
      count_in        = count_ff;
      wr_en           = 1'b0;
      cmd_data.op     = OP_NONE;
      cmd_data.status = ST_OK;
      cmd_data.qx     = req_data.coord_x;
      cmd_data.qy     = req_data.coord_y;
      cmd_data.key    = req_data.search_key;
      case (req_data.action)
         ACT_CLEAR: begin
            if (accept) count_in = '0;
         end
         ACT_APPEND: begin
            if (full) begin
               cmd_data.status = ST_FULL;
            end else begin
               wr_en = accept;
               if (accept) count_in = count_ff + 1'b1;
            end
         end
         ACT_NEAREST, ACT_LB_STA, ACT_LB_TIME: begin
            if (count_ff == '0) begin
               cmd_data.status = ST_EMPTY;
            end else begin
               case (req_data.action)
                  ACT_NEAREST: cmd_data.op = OP_NEAREST;
                  ACT_LB_STA:  cmd_data.op = OP_LB_STA;
                  default:     cmd_data.op = OP_LB_TIME;
               endcase
            end
         end
         default: ;
      endcase
   end

   assign wr_addr = count_ff[ADDR_BITS-1:0];
   assign wr_data = {VALUE_BITS'(req_data.coord_x), VALUE_BITS'(req_data.coord_y),
                     VALUE_BITS'(req_data.point_station), VALUE_BITS'(req_data.point_time)};

   always_ff @(posedge clock) begin
      if (reset) count_ff <= '0;
      else       count_ff <= count_in;
   end

endmodule

### rtl/tps_queue.sv
// ----------------------------------------------------------------------------
// tps_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module tps_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  tps_pkg::cmd_type in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output tps_pkg::cmd_type out_data
);
   import tps_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

### rtl/tps_back.sv
// ----------------------------------------------------------------------------
// tps_back
// point memories, scan for nearest or lower bound, bit-serial square root
// ----------------------------------------------------------------------------
module tps_back #(
   parameter int unsigned MAX_POINTS = 1024,
   parameter int unsigned CNT_BITS   = 11,
   parameter int unsigned ADDR_BITS  = 10,
   parameter int unsigned VALUE_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   output logic                    cmd_ready,
   input  tps_pkg::cmd_type        cmd_data,
   input  logic [CNT_BITS-1:0]     count,
   input  logic                    wr_en,
   input  logic [ADDR_BITS-1:0]    wr_addr,
   input  logic [4*VALUE_BITS-1:0] wr_data,
   output logic                    scan_busy,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output tps_pkg::rsp_type        rsp_data
);
   import tps_pkg::*;

   localparam int unsigned DW  = VALUE_BITS + 1;
   localparam int unsigned SQW = 2 * DW + 1;
   localparam int unsigned RIT = SQD_BITS / 2;

   logic [VALUE_BITS-1:0] mem_x [MAX_POINTS];
   logic [VALUE_BITS-1:0] mem_y [MAX_POINTS];
   logic [VALUE_BITS-1:0] mem_s [MAX_POINTS];
   logic [VALUE_BITS-1:0] mem_t [MAX_POINTS];
   logic [VALUE_BITS-1:0] rd_x_ff, rd_y_ff, rd_s_ff, rd_t_ff;

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [CNT_BITS-1:0]  addr_ff, addr_in;
   logic [CNT_BITS-1:0]  num_ff, num_in;
   logic                 rdv_ff, rdv_in;
   logic [ADDR_BITS-1:0] ridx_ff, ridx_in;
   logic                 rlast_ff, rlast_in;
   logic                 dv_ff;
   logic [ADDR_BITS-1:0] didx_ff;
   logic                 dlast_ff;
   logic [SQW-1:0]       dist_ff;
   logic [VALUE_BITS-1:0] dcol_ff;
   logic [SQW-1:0]       best_ff, best_in;
   logic [ADDR_BITS-1:0] bidx_ff, bidx_in;
   logic                 have_ff, have_in;
   logic                 lb_found_ff, lb_found_in;
   logic [ADDR_BITS-1:0] lb_idx_ff, lb_idx_in;
   logic [SQD_BITS-1:0]  rem_ff, rem_in;
   logic [ROOT_BITS-1:0] root_ff, root_in;
   logic [SQD_BITS-1:0]  sqd_ff, sqd_in;
   logic [$clog2(RIT+1)-1:0] rit_ff, rit_in;
   logic [SQD_BITS-1:0]  src_ff, src_in;
   rsp_type              out_ff, out_in;
   logic                 ov_ff, ov_in;

   logic signed [DW-1:0] dx, dy;
   logic [2*DW-1:0]      sqx, sqy;
   logic [VALUE_BITS-1:0] col_val;
   logic [SQD_BITS+1:0]  trial;
   logic [SQD_BITS+1:0]  rem_sh;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= wr_data[4*VALUE_BITS-1 -: VALUE_BITS];
         mem_y[wr_addr] <= wr_data[3*VALUE_BITS-1 -: VALUE_BITS];
         mem_s[wr_addr] <= wr_data[2*VALUE_BITS-1 -: VALUE_BITS];
         mem_t[wr_addr] <= wr_data[VALUE_BITS-1:0];
      end
      rd_x_ff <= mem_x[addr_ff[ADDR_BITS-1:0]];
      rd_y_ff <= mem_y[addr_ff[ADDR_BITS-1:0]];
      rd_s_ff <= mem_s[addr_ff[ADDR_BITS-1:0]];
      rd_t_ff <= mem_t[addr_ff[ADDR_BITS-1:0]];
   end

   assign dx  = DW'($signed(rd_x_ff)) - DW'($signed(cmd_ff.qx[VALUE_BITS-1:0]));
   assign dy  = DW'($signed(rd_y_ff)) - DW'($signed(cmd_ff.qy[VALUE_BITS-1:0]));
   assign sqx = (2*DW)'(dx * dx);
   assign sqy = (2*DW)'(dy * dy);
   assign col_val = (cmd_ff.op == OP_LB_STA) ? rd_s_ff : rd_t_ff;
   assign rem_sh  = {rem_ff, src_ff[SQD_BITS-1 -: 2]};
   assign trial   = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      dist_ff  <= SQW'(sqx) + SQW'(sqy);
      dcol_ff  <= col_val;
      didx_ff  <= ridx_ff;
      dlast_ff <= rlast_ff;
   end

   assign cmd_ready = (state_ff == BK_IDLE) && !ov_ff;
   assign scan_busy = (state_ff != BK_IDLE);

   always_comb begin
      state_in    = state_ff;
      cmd_in      = cmd_ff;
      addr_in     = addr_ff;
      num_in      = num_ff;
      rdv_in      = 1'b0;
      ridx_in     = addr_ff[ADDR_BITS-1:0];
      rlast_in    = (addr_ff == num_ff - 1'b1);
      best_in     = best_ff;
      bidx_in     = bidx_ff;
      have_in     = have_ff;
      lb_found_in = lb_found_ff;
      lb_idx_in   = lb_idx_ff;
      rem_in      = rem_ff;
      root_in     = root_ff;
      sqd_in      = sqd_ff;
      rit_in      = rit_ff;
      src_in      = src_ff;
      out_in      = out_ff;
      ov_in       = ov_ff;
      if (ov_ff && rsp_ready) ov_in = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (cmd_valid && cmd_ready) begin
               cmd_in  = cmd_data;
               addr_in = '0;
               num_in  = count;
               have_in = 1'b0;
               lb_found_in = 1'b0;
               lb_idx_in   = ADDR_BITS'(count - 1'b1);
               if (cmd_data.op == OP_NONE) begin
                  out_in = '{found_index: '0, squared_distance: '0,
                             root_distance: '0, status: cmd_data.status};
                  ov_in  = 1'b1;
               end else begin
                  state_in = BK_SCAN;
               end
            end
         end
         BK_SCAN: begin
            rdv_in  = 1'b1;
            addr_in = addr_ff + 1'b1;
            if (addr_ff == num_ff - 1'b1) state_in = BK_DRAIN;
         end
         BK_DRAIN: begin
            if (dv_ff && dlast_ff) begin
               if (cmd_ff.op == OP_NEAREST) begin
                  state_in = BK_ROOT;
               end else begin
                  state_in = BK_DONE;
               end
            end
         end
         BK_ROOT: begin
            if (rit_ff == '0) begin
               state_in = BK_DONE;
            end else begin
               rit_in = rit_ff - 1'b1;
               src_in = src_ff << 2;
               if (rem_sh >= trial) begin
                  rem_in  = SQD_BITS'(rem_sh - trial);
                  root_in = {root_ff[ROOT_BITS-2:0], 1'b1};
               end else begin
                  rem_in  = SQD_BITS'(rem_sh);
                  root_in = {root_ff[ROOT_BITS-2:0], 1'b0};
               end
            end
         end
         BK_DONE: begin
            if (!ov_ff || rsp_ready) begin
               if (cmd_ff.op == OP_NEAREST) begin
                  out_in = '{found_index: INDEX_BITS'(bidx_ff), squared_distance: sqd_ff,
                             root_distance: root_ff, status: ST_OK};
               end else begin
                  out_in = '{found_index: INDEX_BITS'(lb_idx_ff), squared_distance: '0,
                             root_distance: '0, status: ST_OK};
               end
               ov_in    = 1'b1;
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
      // per-element result update, one stage after the memory read
      if (dv_ff && (state_ff == BK_SCAN || state_ff == BK_DRAIN)) begin
         if (cmd_ff.op == OP_NEAREST) begin
            if (!have_ff || dist_ff < best_ff) begin
               best_in = dist_ff;
               bidx_in = didx_ff;
               have_in = 1'b1;
            end
         end else begin
            if (!lb_found_ff && dcol_ff >= cmd_ff.key[VALUE_BITS-1:0]) begin
               lb_found_in = 1'b1;
               lb_idx_in   = didx_ff;
            end
         end
         if (dlast_ff) begin
            if (cmd_ff.op != OP_NEAREST) begin
               if (cmd_ff.key[VALUE_BITS-1:0] >= dcol_ff) lb_idx_in = didx_ff;
            end else begin
               sqd_in = (best_in > SQW'({SQD_BITS{1'b1}})) ? {SQD_BITS{1'b1}}
                                                          : SQD_BITS'(best_in);
               src_in  = sqd_in;
               rem_in  = '0;
               root_in = '0;
               rit_in  = ($clog2(RIT+1))'(RIT);
            end
         end
      end
   end

   // rdv_ff tracks rd data validity, as a read issued in scan lands in the next cycle; dv_ff follows it for dist_ff
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      addr_ff      <= addr_in;
      num_ff       <= num_in;
      ridx_ff      <= ridx_in;
      rlast_ff     <= rlast_in;
      best_ff      <= best_in;
      bidx_ff      <= bidx_in;
      lb_idx_ff    <= lb_idx_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      sqd_ff       <= sqd_in;
      rit_ff       <= rit_in;
      src_ff       <= src_in;
      out_ff       <= out_in;
      have_ff      <= have_in;
      lb_found_ff  <= lb_found_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         rdv_ff   <= 1'b0;
         dv_ff    <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rdv_ff   <= rdv_in;
         dv_ff    <= rdv_ff;
         ov_ff    <= ov_in;
      end
   end

   assign rsp_valid = ov_ff;
   assign rsp_data  = out_ff;

endmodule

### rtl/trajectory_point_search.sv
// ----------------------------------------------------------------------------
// trajectory_point_search
// path from request to response valid: clear, append and errors pass the queue
// and the output register; queries add a scan over the stored points, and nearest
// also a 25-step square root (memory read and distance registers, then the root)
// sequential: one query in the back end at a time, up to two more queued;
// appends and clears wait while any transaction is queued or in the back end
// synchronous active-high reset empties the table and the queue
// ----------------------------------------------------------------------------
module trajectory_point_search (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  tps_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output tps_pkg::rsp_type rsp_data
);
   import tps_pkg::*;

   localparam int unsigned MAX_POINTS = TABLE_POINTS;
   localparam int unsigned VALUE_BITS = FIELD_BITS;
   localparam int unsigned CNT_BITS   = $clog2(MAX_POINTS + 1);
   localparam int unsigned ADDR_BITS  = $clog2(MAX_POINTS);

   logic                    fq_valid, fq_ready, qb_valid, qb_ready, wr_en;
   logic                    scan_busy, back_busy;
   cmd_type                 fq_data, qb_data;
   logic [CNT_BITS-1:0]     count;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [4*VALUE_BITS-1:0] wr_data;

   assign back_busy = qb_valid || scan_busy;

   tps_front #(.MAX_POINTS(MAX_POINTS), .CNT_BITS(CNT_BITS), .ADDR_BITS(ADDR_BITS),
               .VALUE_BITS(VALUE_BITS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data, .back_busy,
      .cmd_valid(fq_valid), .cmd_ready(fq_ready), .cmd_data(fq_data),
      .count, .wr_en, .wr_addr, .wr_data
   );

   tps_queue u_queue (
      .clock, .reset,
      .in_valid(fq_valid), .in_ready(fq_ready), .in_data(fq_data),
      .out_valid(qb_valid), .out_ready(qb_ready), .out_data(qb_data)
   );

   tps_back #(.MAX_POINTS(MAX_POINTS), .CNT_BITS(CNT_BITS), .ADDR_BITS(ADDR_BITS),
              .VALUE_BITS(VALUE_BITS)) u_back (
      .clock, .reset,
      .cmd_valid(qb_valid), .cmd_ready(qb_ready), .cmd_data(qb_data),
      .count, .wr_en, .wr_addr, .wr_data, .scan_busy,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

### rtl/tps_checker.sv
// ----------------------------------------------------------------------------
// tps_checker
// port-level checks on the trajectory point search block
// ----------------------------------------------------------------------------
module tps_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input tps_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input tps_pkg::rsp_type rsp_data
);
   import tps_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp transaction dropped or changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.status != 2'd3)
      else $error("bad status code");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_OK |->
         rsp_data.found_index == '0 && rsp_data.squared_distance == '0)
      else $error("error transaction carries data");

   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind trajectory_point_search tps_checker u_tps_checker (
   .clock, .reset, .req_valid, .req_ready, .req_data,
   .rsp_valid, .rsp_ready, .rsp_data
);
